FILE: rtl/core/positional_insert_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional insert queue
// Shared property templates, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_QUEUE_UNIT_ASSERT_SVH
`define POSITIONAL_INSERT_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Queue check failed in the same cycle.");

// The consequent must hold in the cycle after the antecedent.
`define PIQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Queue check failed in the following cycle.");

`endif

FILE: rtl/core/piq_pkg.sv
// ----------------------------------------------------------------------------
// Positional insert queue package
// Sizes, item and result codes and the controller types.
// ----------------------------------------------------------------------------
package piq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 64;
  localparam int FIELD_W   = 64;
  localparam int POS_W     = 8;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);

  typedef enum logic [1:0] {
    K_APPEND = 2'd0,
    K_INSERT = 2'd1,
    K_REMOVE = 2'd2
  } piq_kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } piq_status_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_HOLD = 1'b1
  } piq_state_t;

  typedef struct packed {
    logic op_en;
    logic out_load;
  } piq_cmd_t;

endpackage

FILE: rtl/core/piq_ctrl.sv
// ----------------------------------------------------------------------------
// Positional insert queue controller
// Tracks whether a result is held and issues the per-transaction command.
// ----------------------------------------------------------------------------
module piq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output piq_pkg::piq_cmd_t cmd
);
  import piq_pkg::*;

  piq_state_t state_r;
  piq_state_t state_nxt;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (accept) state_nxt = CS_HOLD;
      end
      CS_HOLD: begin
        if (accept) begin
          state_nxt = CS_HOLD;
        end else if (out_ready) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      CS_IDLE: begin
        in_ready  = 1'b1;
        out_valid = 1'b0;
      end
      CS_HOLD: begin
        in_ready  = out_ready;
        out_valid = 1'b1;
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
    cmd.op_en    = in_valid && in_ready;
    cmd.out_load = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/piq_datapath.sv
// ----------------------------------------------------------------------------
// Positional insert queue datapath
// A row of entry cells that shifts on the accepting edge, the fill count and the
// result register.
// ----------------------------------------------------------------------------
`include "positional_insert_queue_unit_assert.svh"

module piq_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  piq_pkg::piq_cmd_t          cmd,
  input  logic [1:0]                 in_kind,
  input  logic [piq_pkg::FIELD_W-1:0] in_entry_id,
  input  logic [piq_pkg::FIELD_W-1:0] in_entry_name,
  input  logic [piq_pkg::POS_W-1:0]  in_position,
  output logic [1:0]                 out_status,
  output logic [piq_pkg::CNT_W-1:0]  out_count,
  output logic [piq_pkg::FIELD_W-1:0] out_head_id,
  output logic [piq_pkg::FIELD_W-1:0] out_head_name
);
  import piq_pkg::*;

  logic [WORD_BITS-1:0] id_r   [DEPTH];
  logic [WORD_BITS-1:0] name_r [DEPTH];
  logic [WORD_BITS-1:0] id_nxt   [DEPTH];
  logic [WORD_BITS-1:0] name_nxt [DEPTH];

  logic [CNT_W-1:0]     fill_r;
  logic [CNT_W-1:0]     fill_nxt;
  piq_status_t          status_r;
  piq_status_t          status_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [WORD_BITS-1:0] head_id_r;
  logic [WORD_BITS-1:0] head_name_r;
  logic [WORD_BITS-1:0] head_id_nxt;
  logic [WORD_BITS-1:0] head_name_nxt;

  logic [WORD_BITS-1:0] new_id;
  logic [WORD_BITS-1:0] new_name;
  logic                 is_add;
  logic                 is_rem;
  logic                 full;
  logic                 empty;
  logic                 do_ins;
  logic                 do_rem;
  logic [IDX_W-1:0]     slot;

  assign new_id   = in_entry_id[WORD_BITS-1:0];
  assign new_name = in_entry_name[WORD_BITS-1:0];
  assign is_add   = (in_kind == K_APPEND) || (in_kind == K_INSERT);
  assign is_rem   = (in_kind == K_REMOVE);
  assign full     = (fill_r == CNT_W'(DEPTH));
  assign empty    = (fill_r == '0);
  assign do_ins   = cmd.op_en && is_add && !full;
  assign do_rem   = cmd.op_en && is_rem && !empty;

  always_comb begin
    if ((in_kind == K_APPEND) || (in_position > POS_W'(fill_r))) begin
      slot = fill_r[IDX_W-1:0];
    end else if (in_position <= POS_W'(1)) begin
      slot = '0;
    end else begin
      slot = IDX_W'(in_position - POS_W'(1));
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_BITS-1:0] up_id;
      logic [WORD_BITS-1:0] up_name;
      logic [WORD_BITS-1:0] dn_id;
      logic [WORD_BITS-1:0] dn_name;

      if (g == 0) begin : g_first
        assign dn_id   = id_r[g];
        assign dn_name = name_r[g];
      end else begin : g_rest
        assign dn_id   = id_r[g-1];
        assign dn_name = name_r[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
        assign up_id   = id_r[g];
        assign up_name = name_r[g];
      end else begin : g_inner
        assign up_id   = id_r[g+1];
        assign up_name = name_r[g+1];
      end

      always_comb begin
        id_nxt[g]   = id_r[g];
        name_nxt[g] = name_r[g];
        if (do_ins) begin
          if (IDX_W'(g) == slot) begin
            id_nxt[g]   = new_id;
            name_nxt[g] = new_name;
          end else if (IDX_W'(g) > slot) begin
            id_nxt[g]   = dn_id;
            name_nxt[g] = dn_name;
          end
        end else if (do_rem) begin
          id_nxt[g]   = up_id;
          name_nxt[g] = up_name;
        end
      end

      always_ff @(posedge clk) begin
        id_r[g]   <= id_nxt[g];
        name_r[g] <= name_nxt[g];
      end
    end
  endgenerate

  always_comb begin
    fill_nxt      = fill_r;
    status_nxt    = ST_DONE;
    head_id_nxt   = empty ? '0 : id_r[0];
    head_name_nxt = empty ? '0 : name_r[0];
    if (is_add && full) begin
      status_nxt = ST_FULL;
    end else if (is_rem && empty) begin
      status_nxt = ST_EMPTY;
    end
    if (do_ins) begin
      fill_nxt = fill_r + CNT_W'(1);
      if (slot == '0) begin
        head_id_nxt   = new_id;
        head_name_nxt = new_name;
      end
    end else if (do_rem) begin
      fill_nxt = fill_r - CNT_W'(1);
      if (fill_r > CNT_W'(1)) begin
        head_id_nxt   = id_r[1];
        head_name_nxt = name_r[1];
      end else begin
        head_id_nxt   = '0;
        head_name_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.op_en) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r    <= status_nxt;
      count_r     <= fill_nxt;
      head_id_r   <= head_id_nxt;
      head_name_r <= head_name_nxt;
    end
  end

  assign out_status    = status_r;
  assign out_count     = count_r;
  assign out_head_id   = FIELD_W'(head_id_r);
  assign out_head_name = FIELD_W'(head_name_r);

  `PIQ_ASSERT_SAME(a_fill_bound, 1'b1, fill_r <= CNT_W'(DEPTH))
  `PIQ_ASSERT_NEXT(a_rem_empty, cmd.op_en && is_rem && empty,
                   fill_r == '0 && status_r == ST_EMPTY)
  `PIQ_ASSERT_NEXT(a_add_grows, cmd.op_en && is_add && !full,
                   fill_r == $past(fill_r) + CNT_W'(1) && status_r == ST_DONE)
  `PIQ_ASSERT_NEXT(a_count_tracks, cmd.op_en, count_r == fill_r)

endmodule

FILE: rtl/core/positional_insert_queue_unit.sv
// ----------------------------------------------------------------------------
// Positional insert queue unit
// Ordered queue of id and name entries with append, positional insert and
// head removal; one result per transaction.
// ----------------------------------------------------------------------------
//   Channel | Ports                                   | Direction
//   in      | in_valid/in_ready, kind, id, name, pos   | into the queue
//   out     | out_valid/out_ready, status, count, head | from the queue
//
// Every transaction completes at the accepting edge: the row of entry cells
// shifts and the result register loads.
// A new transaction is accepted in the same cycle a held result is taken.
// Reset clears the fill count and drops any held result; entry cells and the
// result register are not reset.
// While a result waits for out_ready, no new transaction is accepted.
module positional_insert_queue_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [piq_pkg::FIELD_W-1:0] in_entry_id,
  input  logic [piq_pkg::FIELD_W-1:0] in_entry_name,
  input  logic [piq_pkg::POS_W-1:0]   in_position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [piq_pkg::CNT_W-1:0]   out_count,
  output logic [piq_pkg::FIELD_W-1:0] out_head_id,
  output logic [piq_pkg::FIELD_W-1:0] out_head_name
);
  import piq_pkg::*;

  piq_cmd_t cmd;

  piq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  piq_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_kind       (in_kind),
    .in_entry_id   (in_entry_id),
    .in_entry_name (in_entry_name),
    .in_position   (in_position),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_head_id   (out_head_id),
    .out_head_name (out_head_name)
  );

endmodule
